// ===== hw/rtl/tcw_pkg.sv =====
// shared types, constants and field widths of the text console writer
package tcw_pkg;

   // default geometry limits and tab spacing
   localparam int TCW_MAX_COLUMNS = 128;
   localparam int TCW_MAX_ROWS    = 32;
   localparam int TCW_TAB_STOP    = 8;

   // item and result field widths
   localparam int MODE_W     = 2;
   localparam int CHAR_W     = 8;
   localparam int COORD_W    = 8;
   localparam int OUT_COL_W  = 7;
   localparam int OUT_ROW_W  = 5;
   localparam int OFFSET_W   = 12;
   localparam int CELL_W     = 16;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   // register port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam int COLUMNS_W  = 8;
   localparam int ROWS_W     = 6;
   localparam int COLOR_W    = 4;

   localparam logic [CSR_ADDR_W-1:0] CSR_COLUMNS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROWS    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FORE    = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_BACK    = 2'd3;

   localparam logic [COLUMNS_W-1:0] COLUMNS_RESET = 8'd80;
   localparam logic [ROWS_W-1:0]    ROWS_RESET    = 6'd25;
   localparam logic [COLOR_W-1:0]   FORE_RESET    = 4'd7;
   localparam logic [COLOR_W-1:0]   BACK_RESET    = 4'd0;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SET   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

   // control characters
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_PUT,
      OP_TAB,
      OP_BACK,
      OP_SET,
      OP_ADVANCE,
      OP_SCROLL_STEP,
      OP_ROW_INIT,
      OP_CLEAR_INIT,
      OP_FILL_STEP,
      OP_READ,
      OP_CAPTURE
   } tcw_op_type;

   typedef struct packed {
      logic       accept;
      logic       load_rsp;
      tcw_op_type op;
   } tcw_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              is_nul;
      logic              is_bs;
      logic              is_tab;
      logic              is_nl;
      logic              at_home;
      logic              x_last;
      logic              y_last;
      logic              tab_end;
      logic              scroll_done;
      logic              fill_done;
   } tcw_stat_type;

endpackage

// ===== hw/rtl/text_console_writer_core.sv =====
// top level of the text console writer: stream packing, controller and datapath
//
//   channel   dir   handshake              payload
//   req       in    req_tvalid/req_tready  mode, char_code, column, row
//   rsp       out   rsp_tvalid/rsp_tready  cursor_column, cursor_row, cursor_offset, cell_data
//   csr       in    csr_wr_en              csr_addr selects register, csr_wdata
//
// a row wrap adds an advance step, a read cell adds a capture step for the registered store read,
// a tab writes one space per step; the output register holds a waiting result so the
//   next item can be accepted while the previous result waits on rsp_tready
// a scroll copies cols*(rows-1) cells up a row, then writes cols blank cells into the last row
// clear screen fills all MAX_COLUMNS*MAX_ROWS cells of the store
// after reset the store is wiped one cell per cycle, req_tready rises once the wipe is done
module text_console_writer_core
   import tcw_pkg::*;
#(
   parameter int MAX_COLUMNS = TCW_MAX_COLUMNS,
   parameter int MAX_ROWS    = TCW_MAX_ROWS,
   parameter int TAB_STOP    = TCW_TAB_STOP
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [1:0] mode, [9:2] char_code, [17:10] column, [25:18] row, [31:26] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [6:0] cursor_column, [11:7] cursor_row, [23:12] cursor_offset, [39:24] cell_data
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // register writes
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   tcw_cmd_type  cmd;
   tcw_stat_type stat;

   logic [OUT_COL_W-1:0] rsp_cursor_column;
   logic [OUT_ROW_W-1:0] rsp_cursor_row;
   logic [OFFSET_W-1:0]  rsp_cursor_offset;
   logic [CELL_W-1:0]    rsp_cell_data;

   // sequencing: accept, operation steps, hand the result to the output register
   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // cursor, geometry, screen store and result payload
   tcw_dpath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .TAB_STOP    (TAB_STOP)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .req_mode          (req_tdata[1:0]),
      .req_char_code     (req_tdata[9:2]),
      .req_column        (req_tdata[17:10]),
      .req_row           (req_tdata[25:18]),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_offset (rsp_cursor_offset),
      .rsp_cell_data     (rsp_cell_data)
   );

   // result fields packed from the lowest bit up
   assign rsp_tdata = {rsp_cell_data, rsp_cursor_offset, rsp_cursor_row, rsp_cursor_column};

endmodule

// ===== hw/rtl/tcw_ram.sv =====
// generic simple dual port ram with registered read
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// controller state machine of the text console writer
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  tcw_stat_type stat,
   output tcw_cmd_type  cmd
);

   localparam logic [2:0] S_WIPE   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_TAB    = 3'd3;
   localparam logic [2:0] S_ADV    = 3'd4;
   localparam logic [2:0] S_SCROLL = 3'd5;
   localparam logic [2:0] S_FILL   = 3'd6;
   localparam logic [2:0] S_RDATA  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       pend_ff, pend_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       finish;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && (!pend_ff || out_free);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      finish       = 1'b0;
      cmd.accept   = 1'b0;
      cmd.load_rsp = 1'b0;
      cmd.op       = OP_NONE;
      unique case (state_ff)
         S_WIPE: begin
            if (stat.fill_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.op = OP_FILL_STEP;
            end
         end
         S_IDLE: begin
            cmd.load_rsp = pend_ff && out_free;
            if (req_tvalid && req_tready) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (stat.mode)
               MODE_PUT: begin
                  priority if (stat.is_nul) begin
                     finish = 1'b1;
                  end else if (stat.is_bs) begin
                     if (!stat.at_home) begin
                        cmd.op = OP_BACK;
                     end
                     finish = 1'b1;
                  end else if (stat.is_nl) begin
                     cmd.op = OP_ADVANCE;
                     if (stat.y_last) begin
                        state_in = S_SCROLL;
                     end else begin
                        finish = 1'b1;
                     end
                  end else if (stat.is_tab) begin
                     state_in = S_TAB;
                  end else begin
                     cmd.op = OP_PUT;
                     if (stat.x_last) begin
                        state_in = S_ADV;
                     end else begin
                        finish = 1'b1;
                     end
                  end
               end
               MODE_SET: begin
                  cmd.op = OP_SET;
                  finish = 1'b1;
               end
               MODE_CLEAR: begin
                  cmd.op   = OP_CLEAR_INIT;
                  state_in = S_FILL;
               end
               MODE_READ: begin
                  cmd.op   = OP_READ;
                  state_in = S_RDATA;
               end
            endcase
         end
         S_TAB: begin
            cmd.op = OP_TAB;
            if (stat.tab_end) begin
               if (stat.x_last) begin
                  state_in = S_ADV;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         S_ADV: begin
            cmd.op = OP_ADVANCE;
            if (stat.y_last) begin
               state_in = S_SCROLL;
            end else begin
               finish = 1'b1;
            end
         end
         S_SCROLL: begin
            if (stat.scroll_done) begin
               cmd.op   = OP_ROW_INIT;
               state_in = S_FILL;
            end else begin
               cmd.op = OP_SCROLL_STEP;
            end
         end
         S_FILL: begin
            if (stat.fill_done) begin
               finish = 1'b1;
            end else begin
               cmd.op = OP_FILL_STEP;
            end
         end
         S_RDATA: begin
            cmd.op = OP_CAPTURE;
            finish = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (finish) begin
         state_in = S_IDLE;
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (cmd.load_rsp) begin
         pend_in = 1'b0;
      end
      if (finish) begin
         pend_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WIPE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/tcw_dpath.sv =====
// datapath of the text console writer: registers, cursor, address unit, screen store
module tcw_dpath
   import tcw_pkg::*;
#(
   parameter int MAX_COLUMNS = TCW_MAX_COLUMNS,
   parameter int MAX_ROWS    = TCW_MAX_ROWS,
   parameter int TAB_STOP    = TCW_TAB_STOP
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [COORD_W-1:0]    req_column,
   input  logic [COORD_W-1:0]    req_row,
   input  tcw_cmd_type           cmd,
   output tcw_stat_type          stat,
   output logic [OUT_COL_W-1:0]  rsp_cursor_column,
   output logic [OUT_ROW_W-1:0]  rsp_cursor_row,
   output logic [OFFSET_W-1:0]   rsp_cursor_offset,
   output logic [CELL_W-1:0]     rsp_cell_data
);

   localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int GCOL_W     = $clog2(MAX_COLUMNS + 1);
   localparam int GROW_W     = $clog2(MAX_ROWS + 1);
   localparam int CX_W       = $clog2(MAX_COLUMNS);
   localparam int CY_W       = $clog2(MAX_ROWS);

   // configuration
   logic [COLUMNS_W-1:0] columns_ff;
   logic [ROWS_W-1:0]    rows_ff;
   logic [COLOR_W-1:0]   fore_ff;
   logic [COLOR_W-1:0]   back_ff;

   // latched item
   logic [MODE_W-1:0]  mode_ff;
   logic [CHAR_W-1:0]  code_ff;
   logic [COORD_W-1:0] col_ff;
   logic [COORD_W-1:0] row_ff;

   logic [CX_W-1:0]   x_ff, x_in, x_sat, sel_x;
   logic [CY_W-1:0]   y_ff, y_in, y_sat, sel_y;
   logic [GCOL_W-1:0] cols;
   logic [GROW_W-1:0] nrows;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] lin;
   logic              x_last, y_last, in_rng, col_ok, row_ok;
   logic [CELL_W-1:0] blank;
   logic [7:0]        attr;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  end_ff, end_in;
   logic [CELL_W-1:0] fill_val_ff, fill_val_in;
   logic              pipe_v_ff, pipe_v_in;
   logic [ADDR_W-1:0] pipe_addr_ff;
   logic              scroll_go;
   logic              rd_ok_ff;
   logic [CELL_W-1:0] data_ff, data_in;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [CELL_W-1:0] wr_data, rd_data;

   logic [MAX_COLUMNS-1:0] tab_last;

   // columns whose successor is a tab stop
   for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_tab
      localparam bit LAST_OF_STOP = ((i + 1) % TAB_STOP) == 0;
      assign tab_last[i] = LAST_OF_STOP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLUMNS_RESET;
         rows_ff    <= ROWS_RESET;
         fore_ff    <= FORE_RESET;
         back_ff    <= BACK_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_COLUMNS: columns_ff <= csr_wdata[COLUMNS_W-1:0];
            CSR_ROWS:    rows_ff    <= csr_wdata[ROWS_W-1:0];
            CSR_FORE:    fore_ff    <= csr_wdata[COLOR_W-1:0];
            CSR_BACK:    back_ff    <= csr_wdata[COLOR_W-1:0];
         endcase
      end
   end

   // saturated geometry
   always_comb begin
      if (columns_ff == '0) begin
         cols = GCOL_W'(1);
      end else if ({1'b0, columns_ff} > 9'(MAX_COLUMNS)) begin
         cols = GCOL_W'(MAX_COLUMNS);
      end else begin
         cols = GCOL_W'(columns_ff);
      end
      if (rows_ff == '0) begin
         nrows = GROW_W'(1);
      end else if ({1'b0, rows_ff} > 7'(MAX_ROWS)) begin
         nrows = GROW_W'(MAX_ROWS);
      end else begin
         nrows = GROW_W'(rows_ff);
      end
   end

   assign attr  = {back_ff, fore_ff};
   assign blank = {attr, CHAR_NUL};

   assign x_sat  = (GCOL_W'(x_ff) >= cols) ? CX_W'(cols - GCOL_W'(1)) : x_ff;
   assign y_sat  = (GROW_W'(y_ff) >= nrows) ? CY_W'(nrows - GROW_W'(1)) : y_ff;
   assign x_last = (GCOL_W'(x_ff) + GCOL_W'(1)) == cols;
   assign y_last = (GROW_W'(y_ff) + GROW_W'(1)) == nrows;
   assign col_ok = 9'(col_ff) < 9'(cols);
   assign row_ok = 8'(row_ff) < 8'(nrows);
   assign in_rng = col_ok && row_ok;

   // one linear address unit, item coordinates on a read, else the cursor
   assign sel_x = (cmd.op == OP_READ) ? CX_W'(col_ff) : x_ff;
   assign sel_y = (cmd.op == OP_READ) ? CY_W'(row_ff) : y_ff;
   assign lin   = ADDR_W'(sel_x) + ADDR_W'(ADDR_W'(sel_y) * ADDR_W'(cols));

   // start of the last row in use, also the length of the scroll copy
   assign base_in = ADDR_W'(ADDR_W'(cols) * ADDR_W'(nrows - GROW_W'(1)));

   assign scroll_go = cnt_ff < CNT_W'(base_ff);

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (cmd.accept) begin
         x_in = x_sat;
         y_in = y_sat;
      end else begin
         unique case (cmd.op)
            OP_PUT, OP_TAB: begin
               if (!x_last) begin
                  x_in = x_ff + CX_W'(1);
               end
            end
            OP_BACK: begin
               if (x_ff == '0) begin
                  x_in = CX_W'(cols - GCOL_W'(1));
                  y_in = y_ff - CY_W'(1);
               end else begin
                  x_in = x_ff - CX_W'(1);
               end
            end
            OP_SET: begin
               if (col_ok) begin
                  x_in = CX_W'(col_ff);
               end
               if (row_ok) begin
                  y_in = CY_W'(row_ff);
               end
            end
            OP_ADVANCE: begin
               x_in = '0;
               if (!y_last) begin
                  y_in = y_ff + CY_W'(1);
               end
            end
            OP_CLEAR_INIT: begin
               x_in = '0;
               y_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // sweep counter shared by scroll copy and fills
   always_comb begin
      cnt_in      = cnt_ff;
      end_in      = end_ff;
      fill_val_in = fill_val_ff;
      unique case (cmd.op)
         OP_ADVANCE: cnt_in = '0;
         OP_SCROLL_STEP: begin
            if (scroll_go) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         OP_ROW_INIT: begin
            cnt_in      = CNT_W'(base_ff);
            end_in      = CNT_W'(base_ff) + CNT_W'(cols);
            fill_val_in = blank;
         end
         OP_CLEAR_INIT: begin
            cnt_in      = '0;
            end_in      = CNT_W'(CELL_COUNT);
            fill_val_in = blank;
         end
         OP_FILL_STEP: cnt_in = cnt_ff + CNT_W'(1);
         default: begin
         end
      endcase
   end

   assign pipe_v_in = (cmd.op == OP_SCROLL_STEP) && scroll_go;

   always_comb begin
      data_in = data_ff;
      if (cmd.accept) begin
         data_in = '0;
      end else if (cmd.op == OP_CAPTURE) begin
         data_in = rd_ok_ff ? rd_data : '0;
      end
   end

   // store ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = lin;
      wr_data = blank;
      if (pipe_v_ff) begin
         wr_en   = 1'b1;
         wr_addr = pipe_addr_ff;
         wr_data = rd_data;
      end else begin
         unique case (cmd.op)
            OP_PUT: begin
               wr_en   = 1'b1;
               wr_data = {attr, code_ff};
            end
            OP_TAB: begin
               wr_en   = 1'b1;
               wr_data = {attr, CHAR_SPACE};
            end
            OP_BACK: begin
               wr_en   = 1'b1;
               wr_addr = lin - ADDR_W'(1);
            end
            OP_FILL_STEP: begin
               wr_en   = 1'b1;
               wr_addr = cnt_ff[ADDR_W-1:0];
               wr_data = fill_val_ff;
            end
            default: begin
            end
         endcase
      end
   end

   assign rd_en   = ((cmd.op == OP_READ) && in_rng) || ((cmd.op == OP_SCROLL_STEP) && scroll_go);
   assign rd_addr = (cmd.op == OP_READ) ? lin : cnt_ff[ADDR_W-1:0] + ADDR_W'(cols);

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff        <= '0;
         y_ff        <= '0;
         cnt_ff      <= '0;
         end_ff      <= CNT_W'(CELL_COUNT);
         fill_val_ff <= '0;
         pipe_v_ff   <= 1'b0;
      end else begin
         x_ff        <= x_in;
         y_ff        <= y_in;
         cnt_ff      <= cnt_in;
         end_ff      <= end_in;
         fill_val_ff <= fill_val_in;
         pipe_v_ff   <= pipe_v_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      pipe_addr_ff <= cnt_ff[ADDR_W-1:0];
      data_ff      <= data_in;
      if (cmd.op == OP_READ) begin
         rd_ok_ff <= in_rng;
      end
      if (cmd.accept) begin
         mode_ff <= req_mode;
         code_ff <= req_char_code;
         col_ff  <= req_column;
         row_ff  <= req_row;
      end
      if (cmd.load_rsp) begin
         rsp_cursor_column <= OUT_COL_W'(x_ff);
         rsp_cursor_row    <= OUT_ROW_W'(y_ff);
         rsp_cursor_offset <= OFFSET_W'(lin);
         rsp_cell_data     <= data_ff;
      end
   end

   assign stat.mode        = mode_ff;
   assign stat.is_nul      = code_ff == CHAR_NUL;
   assign stat.is_bs       = code_ff == CHAR_BS;
   assign stat.is_tab      = code_ff == CHAR_TAB;
   assign stat.is_nl       = code_ff == CHAR_NL;
   assign stat.at_home     = (x_ff == '0) && (y_ff == '0);
   assign stat.x_last      = x_last;
   assign stat.y_last      = y_last;
   assign stat.tab_end     = tab_last[x_ff] || x_last;
   assign stat.scroll_done = !scroll_go && !pipe_v_ff;
   assign stat.fill_done   = cnt_ff == end_ff;

endmodule

// ===== tb/sv/tcw_console_checker.sv =====
// scoreboard for the text console writer: screen and cursor predictor plus result comparison
module tcw_console_checker
   import tcw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    results_due,
   output int                    checked_count,
   output int                    scroll_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CELL_COUNT = TCW_MAX_COLUMNS * TCW_MAX_ROWS;

   typedef struct packed {
      logic [REQ_DATA_W-MODE_W-CHAR_W-2*COORD_W-1:0] pad;
      logic [COORD_W-1:0]                            row;
      logic [COORD_W-1:0]                            column;
      logic [CHAR_W-1:0]                             code;
      logic [MODE_W-1:0]                             mode;
   } console_cmd_type;

   typedef struct packed {
      logic [CELL_W-1:0]    cell_data;
      logic [OFFSET_W-1:0]  offset;
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] col;
   } cursor_view_type;

   logic [CELL_W-1:0]    screen [CELL_COUNT];
   int unsigned          cur_col;
   int unsigned          cur_row;
   logic [COLUMNS_W-1:0] reg_columns;
   logic [ROWS_W-1:0]    reg_rows;
   logic [COLOR_W-1:0]   reg_fore;
   logic [COLOR_W-1:0]   reg_back;
   cursor_view_type      awaited_q [$];

   initial begin
      error_count   = 0;
      results_due   = 0;
      checked_count = 0;
      scroll_count  = 0;
   end

   function automatic int unsigned active_columns();
      if (reg_columns == '0) return 1;
      if (reg_columns > TCW_MAX_COLUMNS) return TCW_MAX_COLUMNS;
      return reg_columns;
   endfunction

   function automatic int unsigned active_rows();
      if (reg_rows == '0) return 1;
      if (reg_rows > TCW_MAX_ROWS) return TCW_MAX_ROWS;
      return reg_rows;
   endfunction

   function automatic logic [7:0] attribute();
      return {reg_back, reg_fore};
   endfunction

   function automatic void poke(int unsigned addr, logic [CELL_W-1:0] value);
      if (addr < CELL_COUNT) screen[addr] = value;
   endfunction

   // cursor to the start of the next row, scrolling up at the bottom
   function automatic void next_line(int unsigned cols, int unsigned nrows);
      int unsigned i;
      cur_col = 0;
      cur_row++;
      if (cur_row >= nrows) begin
         cur_row = nrows - 1;
         for (i = 0; i < cols * (nrows - 1); i++) screen[i] = screen[i + cols];
         for (i = 0; i < cols; i++) poke(cols * (nrows - 1) + i, {attribute(), CHAR_NUL});
         scroll_count++;
      end
   endfunction

   function automatic void type_char(logic [CHAR_W-1:0] code, int unsigned cols,
                                     int unsigned nrows);
      int unsigned tab_end;
      if (code == CHAR_NUL) return;
      if (code == CHAR_BS) begin
         if (cur_col == 0 && cur_row == 0) return;
         if (cur_col != 0) begin
            cur_col--;
         end else begin
            cur_col = cols - 1;
            cur_row--;
         end
         poke(cur_col + cur_row * cols, {attribute(), CHAR_NUL});
         return;
      end
      if (code == CHAR_NL) begin
         cur_col = cols;
      end else if (code == CHAR_TAB) begin
         tab_end = (cur_col / TCW_TAB_STOP + 1) * TCW_TAB_STOP;
         if (tab_end > cols) tab_end = cols;
         while (cur_col < tab_end) begin
            poke(cur_col + cur_row * cols, {attribute(), CHAR_SPACE});
            cur_col++;
         end
      end else begin
         poke(cur_col + cur_row * cols, {attribute(), code});
         cur_col++;
      end
      if (cur_col >= cols) next_line(cols, nrows);
   endfunction

   function automatic cursor_view_type run_command(console_cmd_type cmd);
      cursor_view_type view;
      int unsigned     cols;
      int unsigned     nrows;
      cols  = active_columns();
      nrows = active_rows();
      view.cell_data = '0;
      // a geometry shrink leaves the cursor outside, pull it back in
      if (cur_col >= cols) cur_col = cols - 1;
      if (cur_row >= nrows) cur_row = nrows - 1;
      case (cmd.mode)
         MODE_PUT: type_char(cmd.code, cols, nrows);
         MODE_SET: begin
            if (cmd.column < cols) cur_col = cmd.column;
            if (cmd.row < nrows) cur_row = cmd.row;
         end
         MODE_CLEAR: begin
            foreach (screen[i]) screen[i] = {attribute(), CHAR_NUL};
            cur_col = 0;
            cur_row = 0;
         end
         default: begin
            if (cmd.column < cols && cmd.row < nrows)
               view.cell_data = screen[cmd.column + cmd.row * cols];
         end
      endcase
      view.col    = OUT_COL_W'(cur_col);
      view.row    = OUT_ROW_W'(cur_row);
      view.offset = OFFSET_W'(cur_col + cur_row * cols);
      return view;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      cursor_view_type got;
      cursor_view_type want;
      if (reset) begin
         foreach (screen[i]) screen[i] = '0;
         cur_col     = 0;
         cur_row     = 0;
         reg_columns = COLUMNS_RESET;
         reg_rows    = ROWS_RESET;
         reg_fore    = FORE_RESET;
         reg_back    = BACK_RESET;
         awaited_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_COLUMNS: reg_columns = csr_wdata[COLUMNS_W-1:0];
               CSR_ROWS:    reg_rows    = csr_wdata[ROWS_W-1:0];
               CSR_FORE:    reg_fore    = csr_wdata[COLOR_W-1:0];
               default:     reg_back    = csr_wdata[COLOR_W-1:0];
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (awaited_q.size() == 0) begin
               error_count++;
               $display("%0t: result with nothing pending, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = awaited_q.pop_front();
               checked_count++;
               check_field("cursor_column", want.col, got.col);
               check_field("cursor_row", want.row, got.row);
               check_field("cursor_offset", want.offset, got.offset);
               check_field("cell_data", want.cell_data, got.cell_data);
            end
         end
         if (req_tvalid && req_tready) awaited_q.push_back(run_command(req_tdata));
      end
      results_due <= awaited_q.size();
   end

endmodule

// ===== tb/sv/tb_text_console_writer_core.sv =====
// testbench top of the text console writer: clock, reset, stimulus, ready pattern and verdict
module tb_text_console_writer_core;
   import tcw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     CLK_PERIOD      = 12;
   localparam int     RESET_CYCLES    = 11;
   localparam int     RANDOM_ITEMS    = 1425;
   localparam int     HOLD_OFF_CYCLES = 300;
   localparam int     SETTLE_CYCLES   = 200;
   // watchdog limit on the whole run, in ns, well above the slowest expected run
   localparam longint RUN_LIMIT_NS    = 40_000_000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int error_count;
   int results_due;
   int checked_count;
   int scroll_count;

   // stimulus state shared between the sender and the ready pattern
   bit          hold_off_request = 1'b0;
   bit          sender_steady    = 1'b0;
   int unsigned eff_cols         = 80;
   int unsigned eff_rows         = 25;
   int          mode_count [4]   = '{0, 0, 0, 0};
   int          phase_count      = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   text_console_writer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   tcw_console_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .results_due   (results_due),
      .checked_count (checked_count),
      .scroll_count  (scroll_count)
   );

   // gap length: mostly none or short, now and then a long one
   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // offer one item and hold it until the transfer happens
   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] code,
                            input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
      int gap;
      gap = sender_steady ? 0 : idle_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - MODE_W - CHAR_W - 2 * COORD_W){1'b0}}, row, col, code, mode};
      mode_count[mode]++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop offering and wait until every result has been taken
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   // one register write; the caller lowers the enable after the last one
   task automatic put_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic send_random_item();
      int                 pick;
      int                 roll;
      logic [MODE_W-1:0]  mode;
      logic [CHAR_W-1:0]  code;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      pick = $urandom_range(0, 999);
      roll = $urandom_range(0, 99);
      code = $urandom_range(0, 255);
      col  = $urandom_range(0, 255);
      row  = $urandom_range(0, 255);
      if (pick < 620) begin
         mode = MODE_PUT;
         // control characters get extra weight over plain text
         if (roll < 10) code = CHAR_NL;
         else if (roll < 17) code = CHAR_TAB;
         else if (roll < 25) code = CHAR_BS;
         else if (roll < 28) code = CHAR_NUL;
      end else if (pick < 985) begin
         mode = (pick < 780) ? MODE_SET : MODE_READ;
         // mostly near the screen, one past the edge included; the rest anywhere
         if (roll < 80) begin
            col = $urandom_range(0, eff_cols);
            row = $urandom_range(0, eff_rows);
         end
      end else begin
         mode = MODE_CLEAR;
      end
      send_item(mode, code, col, row);
   endtask

   // response side: random ready gaps, ready stretches and the requested long hold-off
   initial begin : rsp_sink
      int gap;
      int stretch;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         if ($urandom_range(0, 99) < 3) begin
            rsp_tready <= 1'b1;
            // a hold-off request cuts the ready stretch short
            stretch = $urandom_range(100, 300);
            while (stretch > 0 && !hold_off_request) begin
               @(posedge clock);
               stretch--;
            end
         end else begin
            gap = idle_len();
            if (gap != 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] raw_cols;
      logic [CSR_DATA_W-1:0] raw_rows;
      logic [CSR_DATA_W-1:0] fore;
      logic [CSR_DATA_W-1:0] back;
      int                    n;
      int                    sent;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed part on the reset geometry, 80 by 25, gray on black
      send_item(MODE_READ, CHAR_NUL, 8'd0, 8'd0);      // store wiped by reset
      send_item(MODE_PUT, 8'h41, 8'd0, 8'd0);
      send_item(MODE_PUT, CHAR_NUL, 8'd0, 8'd0);       // null leaves everything alone
      send_item(MODE_PUT, 8'hFF, 8'd0, 8'd0);
      send_item(MODE_PUT, CHAR_TAB, 8'd0, 8'd0);       // pads to the next tab stop
      send_item(MODE_PUT, CHAR_BS, 8'd0, 8'd0);
      send_item(MODE_SET, CHAR_NUL, 8'd79, 8'd24);     // bottom right corner
      send_item(MODE_PUT, 8'h5A, 8'd0, 8'd0);          // row end on last row, scrolls
      send_item(MODE_READ, CHAR_NUL, 8'd79, 8'd23);    // the char moved up a row
      send_item(MODE_SET, CHAR_NUL, 8'd255, 8'd255);   // both coordinates refused
      send_item(MODE_SET, CHAR_NUL, 8'd80, 8'd3);      // only the row is taken
      send_item(MODE_PUT, CHAR_NL, 8'd0, 8'd0);
      send_item(MODE_SET, CHAR_NUL, 8'd0, 8'd0);
      send_item(MODE_PUT, CHAR_BS, 8'd0, 8'd0);        // backspace at home does nothing
      send_item(MODE_SET, CHAR_NUL, 8'd0, 8'd1);
      send_item(MODE_PUT, CHAR_BS, 8'd0, 8'd0);        // wraps to the end of the row above
      send_item(MODE_READ, CHAR_NUL, 8'd79, 8'd0);
      send_item(MODE_READ, CHAR_NUL, 8'd255, 8'd255);  // reads outside return zero
      send_item(MODE_READ, CHAR_NUL, 8'd80, 8'd0);
      send_item(MODE_SET, CHAR_NUL, 8'd75, 8'd0);
      send_item(MODE_PUT, CHAR_TAB, 8'd0, 8'd0);       // tab clipped at the row end, wraps
      send_item(MODE_PUT, CHAR_NUL, 8'd0, 8'd0);
      send_item(MODE_CLEAR, CHAR_NUL, 8'd0, 8'd0);
      send_item(MODE_READ, CHAR_NUL, 8'd5, 8'd5);      // blank with the current colors
      send_item(MODE_SET, CHAR_NUL, 8'd70, 8'd20);     // left outside the next geometry
      drain_results();

      // random part: one register setting per phase, the block idle in between
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         fore = $urandom_range(0, 15);
         back = $urandom_range(0, 15);
         case (phase_count)
            0: begin raw_cols = 8'd1;   raw_rows = 8'd1;  fore = 8'd0;  back = 8'd0;  end
            1: begin raw_cols = 8'd128; raw_rows = 8'd2;  fore = 8'd15; back = 8'd15; end
            2: begin raw_cols = 8'd3;   raw_rows = 8'd32; end
            3: begin raw_cols = 8'd128; raw_rows = 8'd32; end
            4: begin raw_cols = 8'd0;   raw_rows = 8'd0;  end   // both saturate to one
            5: begin raw_cols = 8'd255; raw_rows = 8'd63; end   // both saturate to the maximum
            6: begin raw_cols = 8'd8;   raw_rows = 8'd40; end
            7: begin raw_cols = 8'd200; raw_rows = 8'd3;  end
            default: begin
               raw_cols = $urandom_range(1, 20);
               raw_rows = $urandom_range(1, 6);
               if ($urandom_range(0, 9) == 0) raw_cols = $urandom_range(129, 255);
            end
         endcase
         put_reg(CSR_COLUMNS, raw_cols);
         put_reg(CSR_ROWS, raw_rows);
         put_reg(CSR_FORE, fore);
         put_reg(CSR_BACK, back);
         csr_wr_en <= 1'b0;

         eff_cols = (raw_cols == 0) ? 1 : (raw_cols > TCW_MAX_COLUMNS) ? TCW_MAX_COLUMNS : raw_cols;
         eff_rows = (raw_rows == 0) ? 1 : (raw_rows > TCW_MAX_ROWS) ? TCW_MAX_ROWS : raw_rows;

         // every fourth phase the sender runs back to back
         sender_steady = (phase_count % 4 == 1);
         // let the result side stall long enough for the block to back up
         if (phase_count == 2 || phase_count == 9) hold_off_request = 1'b1;

         // a screen of more than 1024 cells makes every scroll walk a large part of the store, keep those short
         n = (eff_cols * eff_rows > 1024) ? 40 : $urandom_range(40, 90);
         if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
         repeat (n) send_random_item();
         sent += n;
         phase_count++;
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d register settings, items: %0d character, %0d cursor, %0d clear, %0d read",
               phase_count + 1, mode_count[MODE_PUT], mode_count[MODE_SET],
               mode_count[MODE_CLEAR], mode_count[MODE_READ]);
      $display("%0d results compared, %0d scrolls predicted", checked_count, scroll_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
